// ----- rtl/dependency_graph_cycle_guard_core_assert.svh -----
// ---------------------------------------------------------------------------
// dependency graph cycle guard assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef DEPENDENCY_GRAPH_CYCLE_GUARD_CORE_ASSERT_SVH
`define DEPENDENCY_GRAPH_CYCLE_GUARD_CORE_ASSERT_SVH

// same-cycle implication
`define DGCG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dgcg assertion failed");

// next-cycle implication
`define DGCG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dgcg assertion failed");

`endif

// ----- rtl/dgcg_pkg.sv -----
// ---------------------------------------------------------------------------
// dgcg_pkg
// types, constants and helper functions of the dependency graph cycle guard
// ---------------------------------------------------------------------------
package dgcg_pkg;

  localparam int TASK_COUNT = 32;
  localparam int ID_W       = 5;
  localparam int ROW_W      = 32;
  localparam int ID_LIMIT   = (TASK_COUNT < ROW_W) ? TASK_COUNT : ROW_W;
  localparam int ADDR_W     = (ID_LIMIT > 1) ? $clog2(ID_LIMIT) : 1;
  localparam logic [ROW_W-1:0] ID_MASK = ROW_W'((64'd1 << ID_LIMIT) - 64'd1);

  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_CHECK = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SELF_DEP  = 3'd1,
    ST_CYCLE     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NOT_DONE  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ROW  = 4'b0010,
    S_WALK = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  typedef struct packed {
    op_e              operation;
    logic [ID_W-1:0]  task_id;
    logic [ID_W-1:0]  prereq_id;
    logic [ROW_W-1:0] present_mask;
    logic [ROW_W-1:0] done_mask;
  } in_t;

  typedef struct packed {
    logic            ok;
    status_e         status;
    logic [ID_W-1:0] blocking_task;
  } out_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [ID_W-1:0] lowest_bit(input logic [ROW_W-1:0] v);
    logic [ID_W-1:0] idx;
    idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = ID_W'(i);
      end
    end
    return idx;
  endfunction

  // true when the id lies outside the task range
  function automatic logic id_bad(input logic [ID_W-1:0] id);
    return ({1'b0, id} >= (ID_W + 1)'(ID_LIMIT));
  endfunction

endpackage

// ----- rtl/dependency_graph_cycle_guard_core.sv -----
// ---------------------------------------------------------------------------
// dependency_graph_cycle_guard_core
// task dependency graph with cycle guard on a single adjacency row memory
// ---------------------------------------------------------------------------
// Input channel in_valid_i / in_stall_o carries one item per beat: an add
// inserts edge task -> prereq unless it is a self dependency, an id is out of
// range, or prereq already reaches task; a check tells whether the task is
// present and all its prerequisites are present and done.
// Output channel out_valid_o / out_stall_i returns exactly one result beat
// per item, held stable while stalled.
// A check reads the task's row and then settles its result. An add whose ids
// pass also walks the reachability closure from the prereq, expanding one
// task per row read; the task itself is never expanded.
// The walk reads one adjacency row per cycle through the single synchronous
// read port of the row memory.
// One item is in work at a time; in_stall_o is high from accept until the
// result has moved into the output register. A result waits inside the block
// while the output register is full and stalled.
// Reset clears all per-row valid bits, so every row reads as empty; no
// clearing pass is needed and the block is ready right after reset.
// ---------------------------------------------------------------------------
`include "dependency_graph_cycle_guard_core_assert.svh"

module dependency_graph_cycle_guard_core
  import dgcg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  state_e             state_q, state_d;
  in_t                item_q;
  logic [ROW_W-1:0]   task_row_q, task_row_d;
  logic [ROW_W-1:0]   reached_q, reached_d;
  logic [ROW_W-1:0]   pending_q, pending_d;
  out_t               res_q, res_d;
  logic               out_valid_q;
  out_t               out_q;

  // adjacency memory with per-row valid bits
  logic [ROW_W-1:0]   adj_mem_q [ID_LIMIT];
  logic [ID_LIMIT-1:0] row_valid_q;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ROW_W-1:0]   rd_data_q;
  logic               rd_hit_q;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ROW_W-1:0]   wr_data;

  logic               in_acc;
  logic               slot_free;
  logic [ROW_W-1:0]   row;
  logic [ROW_W-1:0]   grown;
  logic [ROW_W-1:0]   new_pend;
  logic [ROW_W-1:0]   blockers;
  logic [ROW_W-1:0]   pre_bit;
  logic [ID_W-1:0]    pick;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign row      = (rd_hit_q ? rd_data_q : '0) & ID_MASK;
  assign pre_bit  = ROW_W'(1) << item_q.prereq_id;
  assign grown    = reached_q | row;
  assign new_pend = pending_q | (row & ~reached_q);
  assign pick     = lowest_bit(new_pend);
  assign blockers = row & ~(item_q.present_mask & item_q.done_mask) & ID_MASK;

  always_comb begin
    state_d    = state_q;
    task_row_d = task_row_q;
    reached_d  = reached_q;
    pending_d  = pending_q;
    res_d      = res_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = item_q.task_id[ADDR_W-1:0];
    wr_data    = task_row_q | pre_bit;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          rd_en   = 1'b1;
          rd_addr = in_data_i.task_id[ADDR_W-1:0];
          state_d = S_ROW;
        end
      end
      S_ROW: begin
        task_row_d = row;
        res_d      = '{ok: 1'b0, status: ST_OK, blocking_task: '0};
        state_d    = S_DONE;
        if (item_q.operation == OP_ADD) begin
          if (id_bad(item_q.task_id) || id_bad(item_q.prereq_id)) begin
            res_d.status = ST_NOT_FOUND;
          end else if (item_q.task_id == item_q.prereq_id) begin
            res_d.status = ST_SELF_DEP;
          end else begin
            // walk starts at the prerequisite
            reached_d = pre_bit;
            pending_d = '0;
            rd_en     = 1'b1;
            rd_addr   = item_q.prereq_id[ADDR_W-1:0];
            state_d   = S_WALK;
          end
        end else begin
          if (id_bad(item_q.task_id) || !item_q.present_mask[item_q.task_id]) begin
            res_d.status = ST_NOT_FOUND;
          end else if (blockers != '0) begin
            res_d.status        = ST_NOT_DONE;
            res_d.blocking_task = lowest_bit(blockers);
          end else begin
            res_d.ok = 1'b1;
          end
        end
      end
      S_WALK: begin
        reached_d = grown;
        if (grown[item_q.task_id]) begin
          res_d   = '{ok: 1'b0, status: ST_CYCLE, blocking_task: '0};
          state_d = S_DONE;
        end else if (new_pend == '0) begin
          // closure done without reaching the task: insert the edge
          wr_en   = 1'b1;
          res_d   = '{ok: 1'b1, status: ST_OK, blocking_task: '0};
          state_d = S_DONE;
        end else begin
          pending_d = new_pend & ~(ROW_W'(1) << pick);
          rd_en     = 1'b1;
          rd_addr   = pick[ADDR_W-1:0];
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      row_valid_q <= '0;
      rd_hit_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (wr_en) begin
        row_valid_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_q <= row_valid_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= adj_mem_q[rd_addr];
    end
    if (wr_en) begin
      adj_mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
    task_row_q <= task_row_d;
    reached_q  <= reached_d;
    pending_q  <= pending_d;
    res_q      <= res_d;
    if (state_q == S_DONE && slot_free) begin
      out_q <= res_q;
    end
  end

  `DGCG_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_q))
  `DGCG_ASSERT_NOW(a_write_only_on_ok, wr_en, res_d.ok && state_q == S_WALK)
  `DGCG_ASSERT_NOW(a_pending_in_reached, state_q == S_WALK, (pending_q & ~reached_q) == '0)
  `DGCG_ASSERT_NEXT(a_done_hands_off, state_q == S_DONE && slot_free,
                    out_valid_o && state_q == S_IDLE)
  `DGCG_ASSERT_NOW(a_ok_is_clean, out_valid_o && out_data_o.ok,
                   out_data_o.status == ST_OK && out_data_o.blocking_task == '0)

endmodule

// ----- test/tb_dependency_graph_cycle_guard_core.sv -----
// ---------------------------------------------------------------------------
// tb_dependency_graph_cycle_guard_core
// self-checking bench: a predicted adjacency matrix and reachability walk
// are compared beat by beat against the block, under random idling on both
// channels, long output hold-offs and a full drain in the middle of the run
// ---------------------------------------------------------------------------
import dgcg_pkg::*;

class dep_graph_board;
  logic [ROW_W-1:0] dep_rows [ID_LIMIT];
  logic [ROW_W-1:0] walk_seen;
  logic [ROW_W-1:0] walk_front;
  out_t             verdict_q [$];
  int               fail_count;

  function new();
    for (int i = 0; i < ID_LIMIT; i++) begin
      dep_rows[i] = '0;
    end
    walk_seen  = '0;
    walk_front = '0;
    fail_count = 0;
  endfunction

  function int pending();
    return verdict_q.size();
  endfunction

  // breadth-first walk from one task, bounded to TASK_COUNT rounds
  function bit prereq_reaches(int from, int target);
    logic [ROW_W-1:0] grown;
    walk_seen       = '0;
    walk_seen[from] = 1'b1;
    walk_front      = walk_seen;
    for (int r = 0; r < TASK_COUNT && walk_front != '0; r++) begin
      grown = '0;
      for (int i = 0; i < ID_LIMIT; i++) begin
        if (walk_front[i]) begin
          grown |= dep_rows[i];
        end
      end
      grown &= ID_MASK;
      walk_front = grown & ~walk_seen;
      walk_seen |= grown;
    end
    return walk_seen[target];
  endfunction

  function void note_request(in_t req);
    out_t             verdict;
    int               t;
    int               p;
    logic [ROW_W-1:0] blockers;
    verdict = '0;
    t = int'(req.task_id);
    p = int'(req.prereq_id);
    if (req.operation == OP_ADD) begin
      if (t >= ID_LIMIT || p >= ID_LIMIT) begin
        verdict.status = ST_NOT_FOUND;
      end else if (t == p) begin
        verdict.status = ST_SELF_DEP;
      end else if (prereq_reaches(p, t)) begin
        verdict.status = ST_CYCLE;
      end else begin
        dep_rows[t][p] = 1'b1;
        verdict.ok     = 1'b1;
      end
    end else begin
      if (t >= ID_LIMIT || !req.present_mask[t]) begin
        verdict.status = ST_NOT_FOUND;
      end else begin
        blockers = dep_rows[t] & ~(req.present_mask & req.done_mask) & ID_MASK;
        if (blockers != '0) begin
          verdict.status = ST_NOT_DONE;
          for (int i = 0; i < ROW_W; i++) begin
            if (blockers[i]) begin
              verdict.blocking_task = ID_W'(i);
              break;
            end
          end
        end else begin
          verdict.ok = 1'b1;
        end
      end
    end
    verdict_q = {verdict_q, verdict};
  endfunction

  function void check_verdict(out_t got);
    out_t want;
    if (verdict_q.size() == 0) begin
      $error("result beat with no expectation waiting");
      fail_count++;
      return;
    end
    want = verdict_q.pop_front();
    if (got.ok !== want.ok) begin
      $error("ok mismatch: expected %0d, got %0d", want.ok, got.ok);
      fail_count++;
    end
    if (got.status !== want.status) begin
      $error("status mismatch: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
    if (got.blocking_task !== want.blocking_task) begin
      $error("blocking_task mismatch: expected %0d, got %0d",
             want.blocking_task, got.blocking_task);
      fail_count++;
    end
  endfunction
endclass

module tb_dependency_graph_cycle_guard_core;

  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 800000;
  localparam int RAND_ITEMS  = 1350;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  dep_graph_board board = new();
  bit             hold_req;
  bit             quiet_src;

  dependency_graph_cycle_guard_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic in_t add_req(int t, int p);
    in_t req;
    req.operation    = OP_ADD;
    req.task_id      = ID_W'(t);
    req.prereq_id    = ID_W'(p);
    req.present_mask = $urandom;
    req.done_mask    = $urandom;
    return req;
  endfunction

  function automatic in_t check_req(int t, logic [ROW_W-1:0] pres, logic [ROW_W-1:0] dn);
    in_t req;
    req.operation    = OP_CHECK;
    req.task_id      = ID_W'(t);
    req.prereq_id    = ID_W'($urandom_range(0, 31));
    req.present_mask = pres;
    req.done_mask    = dn;
    return req;
  endfunction

  // mostly edges that point to lower ids, some arbitrary pairs, half checks
  // with masks built around the current row so every verdict shows up
  function automatic in_t random_req();
    int               r;
    int               t;
    logic [ROW_W-1:0] pres;
    logic [ROW_W-1:0] dn;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      t = $urandom_range(1, 31);
      return add_req(t, $urandom_range(0, t - 1));
    end
    if (r < 50) begin
      return add_req($urandom_range(0, 31), $urandom_range(0, 31));
    end
    t    = $urandom_range(0, 31);
    pres = $urandom;
    dn   = $urandom;
    if ($urandom_range(0, 99) < 85) begin
      pres |= board.dep_rows[t] | (32'd1 << t);
    end
    r = $urandom_range(0, 9);
    if (r < 4) begin
      dn |= board.dep_rows[t];
    end else if (r < 6) begin
      dn |= board.dep_rows[t];
      dn[$urandom_range(0, 31)] = 1'b0;
    end
    return check_req(t, pres, dn);
  endfunction

  function int pick_gap();
    int r;
    if ($urandom_range(0, 199) == 0) begin
      quiet_src = !quiet_src;
    end
    if (quiet_src) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // valid stays high across back-to-back beats, so only one assignment per step
  task automatic send_item(in_t req);
    int gap;
    in_data_i  <= req;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    board.note_request(req);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (board.pending() != 0);
  endtask

  initial begin : sink
    int hold_left;
    int stall_left;
    int r;
    bit quiet_sink;
    bit nxt;
    hold_left   = 0;
    stall_left  = 0;
    quiet_sink  = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (out_valid_o && !out_stall_i) begin
          board.check_verdict(out_data_o);
        end
        if (hold_req) begin
          hold_left = HOLD_CYCLES;
          hold_req  = 1'b0;
        end
        if ($urandom_range(0, 299) == 0) begin
          quiet_sink = !quiet_sink;
        end
        nxt = 1'b0;
        if (hold_left > 0) begin
          hold_left--;
          nxt = 1'b1;
        end else if (stall_left > 0) begin
          stall_left--;
          nxt = 1'b1;
        end else if (!quiet_sink) begin
          r = $urandom_range(0, 99);
          if (r >= 95) begin
            stall_left = $urandom_range(10, 40);
            nxt        = 1'b1;
          end else if (r >= 70) begin
            stall_left = $urandom_range(0, 2);
            nxt        = 1'b1;
          end
        end
        out_stall_i <= nxt;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    hold_req   = 1'b0;
    quiet_src  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: missing task, empty row, self edge, repeats, cycles, blockers
    send_item(check_req(0, '0, '1));
    send_item(check_req(31, '1, '0));
    send_item(add_req(5, 5));
    send_item(add_req(0, 31));
    send_item(add_req(0, 31));
    send_item(add_req(31, 0));
    send_item(check_req(0, '1, '0));
    send_item(add_req(0, 7));
    send_item(check_req(0, '1, '0));
    send_item(check_req(0, '1, '1));
    send_item(check_req(0, ~32'h0000_0080, '1));
    send_item(check_req(0, 32'h0000_0001, 32'h0000_0001));
    send_item(check_req(0, '1, 32'h0000_0080));
    // chain 10 -> 11 -> ... -> 18, then closing it needs a deep walk
    for (int i = 10; i < 18; i++) begin
      send_item(add_req(i, i + 1));
    end
    send_item(add_req(18, 10));
    send_item(check_req(10, '1, 32'h0000_0800));

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 300 || n == 1000) begin
        hold_req = 1'b1;
      end
      if (n == 650) begin
        drain_results();
      end
      send_item(random_req());
    end
    in_valid_i <= 1'b0;

    while (board.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);
    if (board.fail_count == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/dgcg_pkg.sv
rtl/dependency_graph_cycle_guard_core.sv
test/tb_dependency_graph_cycle_guard_core.sv
